>>> rtl/core/record_framer_masked_crc32c_macros.svh
// Assertion helpers shared by the framer RTL.
// Each macro expects clk and rst_n in scope.
`ifndef RECORD_FRAMER_MASKED_CRC32C_MACROS_SVH
`define RECORD_FRAMER_MASKED_CRC32C_MACROS_SVH

// same-cycle implication
`define RFM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RFM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/rfm_pkg.sv
// ----------------------------------------------------------------------------
// rfm_pkg
// Types, constants and CRC32C helpers for the masked-CRC record framer.
// ----------------------------------------------------------------------------
package rfm_pkg;

    localparam int LENGTH_BITS = 32;
    localparam int LEN_W       = (LENGTH_BITS < 32) ? LENGTH_BITS : 32;

    localparam logic [31:0] CRC_POLY   = 32'h82F6_3B78;
    localparam logic [31:0] CRC_ONES   = 32'hFFFF_FFFF;
    localparam logic [31:0] MASK_DELTA = 32'hA282_EAD8;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // job kinds passed from front to back
    localparam logic [1:0] JOB_HDR  = 2'd0;
    localparam logic [1:0] JOB_DATA = 2'd1;
    localparam logic [1:0] JOB_ERR  = 2'd2;

    // input actions
    localparam logic ACT_BEGIN = 1'b0;
    localparam logic ACT_DATA  = 1'b1;

    typedef struct packed {
        logic        action;
        logic [31:0] record_length;
        logic [7:0]  data_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       record_end;
        logic       run_last;
        logic       error;
    } result_t;

    // value: length for header jobs, payload byte in [7:0] for data jobs
    // crc:   raw CRC register for the trailer; last: trailer follows
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] value;
        logic [31:0] crc;
        logic        last;
    } job_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // invert, rotate right by 15, add delta
    function automatic logic [31:0] mask_crc(input logic [31:0] crc);
        logic [31:0] c;
        c = crc ^ CRC_ONES;
        return {c[14:0], c[31:15]} + MASK_DELTA;
    endfunction

    function automatic logic [7:0] pick_byte(input logic [31:0] w, input logic [1:0] idx);
        return 8'(w >> {idx, 3'b000});
    endfunction

endpackage

>>> rtl/core/rfm_front.sv
// ----------------------------------------------------------------------------
// rfm_front
// Accepts items, tracks the open record and data CRC, and queues jobs.
// ----------------------------------------------------------------------------
module rfm_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  rfm_pkg::item_t     cmd,
    input  logic               full,
    output logic               push,
    output rfm_pkg::job_t      job
);

    logic [31:0]               crc_reg, crc_next;
    logic [rfm_pkg::LEN_W-1:0] remaining_reg, remaining_next;
    logic                      open_reg, open_next;

    logic [31:0]               len_ext;
    logic [31:0]               data_crc;
    logic                      rem_one;

    assign push     = cmd_valid && !full;
    assign len_ext  = 32'(cmd.record_length[rfm_pkg::LEN_W-1:0]);
    assign data_crc = rfm_pkg::crc_byte(crc_reg, cmd.data_byte);
    assign rem_one  = (remaining_reg == {{(rfm_pkg::LEN_W-1){1'b0}}, 1'b1});

    always_comb begin
        crc_next       = crc_reg;
        remaining_next = remaining_reg;
        open_next      = open_reg;
        job            = '0;
        if (cmd.action == rfm_pkg::ACT_BEGIN) begin
            job.kind       = rfm_pkg::JOB_HDR;
            job.value      = len_ext;
            job.crc        = rfm_pkg::CRC_ONES;
            job.last       = (len_ext == 32'd0);
            crc_next       = rfm_pkg::CRC_ONES;
            remaining_next = cmd.record_length[rfm_pkg::LEN_W-1:0];
            open_next      = (len_ext != 32'd0);
        end else if (!open_reg) begin
            job.kind = rfm_pkg::JOB_ERR;
        end else begin
            job.kind       = rfm_pkg::JOB_DATA;
            job.value      = {24'd0, cmd.data_byte};
            job.crc        = data_crc;
            job.last       = rem_one;
            remaining_next = remaining_reg - 1'b1;
            crc_next       = rem_one ? rfm_pkg::CRC_ONES : data_crc;
            open_next      = !rem_one;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            crc_reg       <= rfm_pkg::CRC_ONES;
            remaining_reg <= '0;
            open_reg      <= 1'b0;
        end else if (push) begin
            crc_reg       <= crc_next;
            remaining_reg <= remaining_next;
            open_reg      <= open_next;
        end
    end

endmodule

>>> rtl/core/rfm_queue.sv
// ----------------------------------------------------------------------------
// rfm_queue
// Small job FIFO between the front and the back.
// ----------------------------------------------------------------------------
`include "record_framer_masked_crc32c_macros.svh"

module rfm_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rfm_pkg::job_t  push_job,
    input  logic           pop,
    output logic           full,
    output logic           head_valid,
    output rfm_pkg::job_t  head
);

    rfm_pkg::job_t               mem [rfm_pkg::QDEPTH];
    logic [rfm_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [rfm_pkg::QCNT_W-1:0] count_reg;

    assign full       = (count_reg == rfm_pkg::QCNT_W'(rfm_pkg::QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];

    always_ff @(posedge clk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `RFM_ASSERT_IMP(a_q_bound, 1'b1, count_reg <= rfm_pkg::QCNT_W'(rfm_pkg::QDEPTH), "queue overfilled")
    `RFM_ASSERT_IMP(a_q_pop_nonempty, pop, head_valid, "pop from empty queue")

endmodule

>>> rtl/core/rfm_back.sv
// ----------------------------------------------------------------------------
// rfm_back
// Serializes queued jobs into framed bytes behind an output register.
// ----------------------------------------------------------------------------
`include "record_framer_masked_crc32c_macros.svh"

module rfm_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  rfm_pkg::job_t     head,
    output logic              pop,
    output logic              res_valid,
    input  logic              res_stall,
    output rfm_pkg::result_t  res
);

    logic [3:0]       step_reg, step_next;
    logic [31:0]      hcrc_reg, hcrc_next, hcrc_base;
    logic             res_valid_reg;
    rfm_pkg::result_t res_reg, res_next;

    logic             fire;
    logic             job_done;
    logic [31:0]      hdr_mask, trl_mask;
    logic [3:0]       data_idx;

    assign fire      = head_valid && (!res_valid_reg || !res_stall);
    assign pop       = fire && job_done;
    assign hdr_mask  = rfm_pkg::mask_crc(hcrc_reg);
    assign trl_mask  = rfm_pkg::mask_crc(head.crc);
    assign data_idx  = step_reg - 4'd1;
    assign hcrc_base = (step_reg == 4'd0) ? rfm_pkg::CRC_ONES : hcrc_reg;

    always_comb begin
        res_next  = '0;
        job_done  = 1'b1;
        hcrc_next = hcrc_reg;
        unique case (head.kind)
            rfm_pkg::JOB_HDR: begin
                if (!step_reg[3]) begin
                    // length bytes 4..7 are always zero
                    res_next.out_byte = step_reg[2] ? 8'd0
                                      : rfm_pkg::pick_byte(head.value, step_reg[1:0]);
                    hcrc_next = rfm_pkg::crc_byte(hcrc_base, res_next.out_byte);
                    job_done  = 1'b0;
                end else if (step_reg < 4'd12) begin
                    res_next.out_byte = rfm_pkg::pick_byte(hdr_mask, step_reg[1:0]);
                    job_done = (step_reg == 4'd11) && !head.last;
                end else begin
                    // zero-length record: empty payload trailer
                    res_next.out_byte   = rfm_pkg::pick_byte(trl_mask, step_reg[1:0]);
                    res_next.record_end = (step_reg == 4'd15);
                    job_done            = (step_reg == 4'd15);
                end
            end
            rfm_pkg::JOB_DATA: begin
                if (step_reg == 4'd0) begin
                    res_next.out_byte = head.value[7:0];
                    job_done          = !head.last;
                end else begin
                    res_next.out_byte   = rfm_pkg::pick_byte(trl_mask, data_idx[1:0]);
                    res_next.record_end = (step_reg == 4'd4);
                    job_done            = (step_reg == 4'd4);
                end
            end
            rfm_pkg::JOB_ERR: begin
                res_next.error = 1'b1;
            end
            default: begin
                job_done = 1'b1;
            end
        endcase
        res_next.run_last = job_done;
    end

    always_comb begin
        step_next = step_reg;
        if (fire) begin
            step_next = job_done ? 4'd0 : step_reg + 4'd1;
        end
    end

    always_ff @(posedge clk) begin
        if (fire) begin
            res_reg  <= res_next;
            hcrc_reg <= hcrc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            step_reg      <= 4'd0;
            res_valid_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            if (fire) begin
                res_valid_reg <= 1'b1;
            end else if (!res_stall) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `RFM_ASSERT_IMP(a_err_single, res_valid_reg && res_reg.error, res_reg.run_last && (res_reg.out_byte == 8'd0), "error item not a lone zero byte")
    `RFM_ASSERT_IMP(a_end_last, res_valid_reg && res_reg.record_end, res_reg.run_last, "record end before last byte of item")
    `RFM_ASSERT_IMP(a_job_held, step_reg != 4'd0, head_valid, "job left queue mid-run")

endmodule

>>> rtl/core/record_framer_masked_crc32c.sv
// An accepted item's first result passes through the queue write and then the output register before it is valid.
// Throughput: 1 payload byte per cycle while res_stall is low; a record-closing byte adds 4 trailer bytes.
// A begin item yields 12 bytes from the output serializer, 16 for a zero-length record.
// The 4-deep job queue lets the input keep taking items while the serializer is busy.
// Reset (rst_n, async, active low) clears the record state, CRC and queue at once.
// ----------------------------------------------------------------------------
// record_framer_masked_crc32c
// Frames payload bytes into length-prefixed records with masked CRC32C.
// ----------------------------------------------------------------------------
module record_framer_masked_crc32c (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  rfm_pkg::item_t    cmd,
    output logic              res_valid,
    input  logic              res_stall,
    output rfm_pkg::result_t  res
);

    logic          push;
    logic          pop;
    logic          full;
    logic          head_valid;
    rfm_pkg::job_t push_job;
    rfm_pkg::job_t head;

    assign cmd_stall = full;

    rfm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .full      (full),
        .push      (push),
        .job       (push_job)
    );

    rfm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head       (head)
    );

    rfm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res)
    );

endmodule
